### hw/rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg - shared types and constants of the console line editor
// Request and result payloads, key codes and the command group that the
// controller hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

	localparam int BUF_DEPTH_DEF = 128;
	localparam int CHAR_W        = 8;

	// Key codes with a meaning of their own
	localparam logic [CHAR_W-1:0] KEY_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] KEY_CTRL_D = 8'h04;
	localparam logic [CHAR_W-1:0] KEY_CTRL_H = 8'h08;
	localparam logic [CHAR_W-1:0] KEY_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] KEY_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] KEY_CTRL_P = 8'h10;
	localparam logic [CHAR_W-1:0] KEY_CTRL_U = 8'h15;
	localparam logic [CHAR_W-1:0] KEY_DEL    = 8'h7F;
	localparam logic [CHAR_W-1:0] KEY_ALT_C  = 8'd199;
	localparam logic [CHAR_W-1:0] KEY_ALT_O  = 8'd211;
	localparam logic [CHAR_W-1:0] KEY_ALT_L  = 8'd208;

	// Request kinds
	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] key_code;
		logic              first_of_read;
	} cle_req_t;

	typedef struct packed {
		logic              echo_valid;
		logic [CHAR_W-1:0] echo_char;
		logic [7:0]        erase_count;
		logic              line_ready;
		logic              dump_request;
		logic              read_empty;
		logic              read_valid;
		logic [CHAR_W-1:0] read_char;
		logic              read_eof;
		logic              read_stop;
	} cle_rsp_t;

	typedef struct packed {
		logic capture;  // latch the incoming request
		logic commit;   // execute the held request and load the result register
	} cle_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/cle_req_if.sv
// ----------------------------------------------------------------------------
// cle_req_if - request channel of the console line editor
// Valid/ready channel carrying one keystroke or byte request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cle_req_if import cle_pkg::*; ();
	logic     valid;
	logic     ready;
	cle_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/cle_rsp_if.sv
// ----------------------------------------------------------------------------
// cle_rsp_if - result channel of the console line editor
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface cle_rsp_if import cle_pkg::*; ();
	logic     valid;
	logic     ready;
	cle_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl - request sequencer of the console line editor
// Capture a request, then execute it once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_ctrl import cle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output cle_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign req_ready   = (state_q == ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == ST_EXEC) && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cle_dp.sv
// ----------------------------------------------------------------------------
// cle_dp - datapath of the console line editor
// Line store, read/commit/edit indices, request and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_dp import cle_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cle_cmd_t cmd,
	input  wire cle_req_t req,
	output cle_rsp_t      rsp
);

	localparam int SW = $clog2(BUF_DEPTH);
	localparam int IW = SW + 1;
	localparam logic [IW:0]   IDX_MOD = (IW+1)'(2 * BUF_DEPTH);
	localparam logic [IW-1:0] IDX_MAX = IW'(2 * BUF_DEPTH - 1);
	localparam logic [IW-1:0] DEPTH_I = IW'(BUF_DEPTH);
	localparam logic [IW-1:0] LAST_I  = IW'(BUF_DEPTH - 1);

	// Indices count modulo twice the depth
	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
		return (a == IDX_MAX) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
		return (a == '0) ? IDX_MAX : a - 1'b1;
	endfunction

	function automatic logic [IW-1:0] idx_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] d;
		d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + IDX_MOD - {1'b0, b});
		return d[IW-1:0];
	endfunction

	function automatic logic [SW-1:0] slot(input logic [IW-1:0] a);
		logic [IW-1:0] s;
		s = (a >= DEPTH_I) ? (a - DEPTH_I) : a;
		return s[SW-1:0];
	endfunction

	cle_req_t    req_q;
	cle_rsp_t    rsp_q;
	cle_rsp_t    rsp_d;
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] cm_idx_q;
	logic [IW-1:0] ed_idx_q;
	logic [IW-1:0] rd_idx_d;
	logic [IW-1:0] cm_idx_d;
	logic [IW-1:0] ed_idx_d;
	logic [IW-1:0] tail;
	logic [IW-1:0] fill;
	logic [CHAR_W-1:0] ch;
	logic [CHAR_W-1:0] rdata;
	logic          st_we;

	assign tail = idx_sub(ed_idx_q, cm_idx_q);
	assign fill = idx_sub(ed_idx_q, rd_idx_q);
	assign ch   = (req_q.key_code == KEY_CR) ? KEY_LF : req_q.key_code;
	assign rsp  = rsp_q;

	always_comb begin
		rsp_d    = '0;
		rd_idx_d = rd_idx_q;
		cm_idx_d = cm_idx_q;
		ed_idx_d = ed_idx_q;
		st_we    = 1'b0;
		if (req_q.kind == KIND_KEY) begin
			priority if (req_q.key_code == KEY_CTRL_P) begin
				rsp_d.dump_request = 1'b1;
			end else if (req_q.key_code == KEY_CTRL_U) begin
				ed_idx_d          = cm_idx_q;
				rsp_d.erase_count = 8'(tail);
			end else if (req_q.key_code == KEY_CTRL_H || req_q.key_code == KEY_DEL) begin
				if (tail != '0) begin
					ed_idx_d          = idx_dec(ed_idx_q);
					rsp_d.erase_count = 8'd1;
				end
			end else if (req_q.key_code == KEY_ALT_C || req_q.key_code == KEY_ALT_O ||
					req_q.key_code == KEY_ALT_L || req_q.key_code == KEY_NUL) begin
				rsp_d = '0;
			end else if (fill < DEPTH_I) begin
				st_we            = 1'b1;
				ed_idx_d         = idx_inc(ed_idx_q);
				rsp_d.echo_valid = 1'b1;
				rsp_d.echo_char  = ch;
				if (ch == KEY_LF || ch == KEY_CTRL_D || fill == LAST_I) begin
					cm_idx_d         = idx_inc(ed_idx_q);
					rsp_d.line_ready = 1'b1;
				end
			end else begin
				rsp_d = '0;
			end
		end else begin
			priority if (rd_idx_q == cm_idx_q) begin
				rsp_d.read_empty = 1'b1;
			end else if (rdata == KEY_CTRL_D) begin
				if (req_q.first_of_read) begin
					rd_idx_d = idx_inc(rd_idx_q);
				end
				rsp_d.read_eof  = 1'b1;
				rsp_d.read_stop = 1'b1;
			end else begin
				rd_idx_d         = idx_inc(rd_idx_q);
				rsp_d.read_valid = 1'b1;
				rsp_d.read_char  = rdata;
				rsp_d.read_stop  = (rdata == KEY_LF);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			cm_idx_q <= '0;
			ed_idx_q <= '0;
		end else if (cmd.commit) begin
			rd_idx_q <= rd_idx_d;
			cm_idx_q <= cm_idx_d;
			ed_idx_q <= ed_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	// The read port always follows the read index; it is stable by execute time
	cle_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (BUF_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (st_we && cmd.commit),
		.waddr (slot(ed_idx_q)),
		.wdata (ch),
		.raddr (slot(rd_idx_q)),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

### hw/rtl/console_line_editor.sv
// ----------------------------------------------------------------------------
// console_line_editor - cooked-mode console input line editor
// Top level: request sequencer plus datapath with the line store.
// ----------------------------------------------------------------------------
// Each request is either a keystroke or a reader asking for one byte, and
// each produces exactly one result. A request is captured into the request
// register, then executed against the indices and the line store,
// whose read port is registered and always tracks the read index. The next
// request is taken right after execute, while the result may still sit in
// the output register; a result stalled downstream holds execute until the
// register frees up. The line store needs no clearing pass after reset:
// readers only ever see committed bytes, which were written first.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor import cle_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cle_req_if.sink   item,
	cle_rsp_if.source result
);

	cle_cmd_t cmd;

	// Sequence capture and execute; own the result valid flag
	cle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (item.valid),
		.req_ready (item.ready),
		.rsp_valid (result.valid),
		.rsp_ready (result.ready),
		.cmd       (cmd)
	);

	// Hold the request, edit the line, drive the result payload
	cle_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (item.data),
		.rsp    (result.data)
	);

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the console line editor
// Pushes keystroke and byte requests through the request channel and checks
// every result against a hand-written one or an in-bench model of the line
// buffer and its read, commit and edit indices. Both channels stall at random,
// except in one calm window. A short directed table, then random line traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cle_pkg::*;

	localparam int DEPTH       = BUF_DEPTH_DEF;
	localparam int IDX_W       = $clog2(2 * DEPTH);
	localparam int RAND_ITEMS  = 1100;
	localparam int CALM_FROM   = 500;
	localparam int CALM_LEN    = 150;
	localparam int IDLE_PCT    = 33;
	localparam int MAX_SHOWN   = 10;
	localparam int DRAIN_WAIT  = 20;
	localparam int CYCLE_LIMIT = 400000;

	// One row of the directed table. When typed is set, want is the result
	// written down by hand; otherwise the line model supplies it.
	typedef struct {
		logic              kind;
		logic [CHAR_W-1:0] key;
		logic              first;
		bit                typed;
		cle_rsp_t          want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cle_req_if item_ch ();
	cle_rsp_if rsp_ch ();

	// Line model: store plus the three indices, counting modulo 2*DEPTH
	logic [CHAR_W-1:0] line_mem [DEPTH];
	logic [IDX_W-1:0]  rd_pos = '0;
	logic [IDX_W-1:0]  cm_pos = '0;
	logic [IDX_W-1:0]  ed_pos = '0;

	cle_rsp_t  owed_rsp [$];    // results still to come, oldest first
	cle_rsp_t  last_rsp;        // model's answer to the latest accepted request
	plan_row_t plan [$];
	bit        call_open = 1'b0;  // a read call has delivered bytes and goes on
	bit        calm = 1'b0;       // no stalls on either side
	int        sent = 0;
	int        mismatches = 0;
	int        cycles = 0;

	console_line_editor #(.BUF_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the line model by one accepted request and return its result.
	function automatic cle_rsp_t apply_request(cle_req_t rq);
		cle_rsp_t          r;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  used;
		logic [IDX_W-1:0]  tail;
		r = '0;
		used = ed_pos - rd_pos;
		tail = ed_pos - cm_pos;
		if (rq.kind == KIND_KEY) begin
			case (rq.key_code)
				KEY_CTRL_P: r.dump_request = 1'b1;
				KEY_CTRL_U: begin
					// only the uncommitted tail can go
					r.erase_count = 8'(tail);
					ed_pos = cm_pos;
				end
				KEY_CTRL_H, KEY_DEL: begin
					if (ed_pos != cm_pos) begin
						ed_pos = ed_pos - 1'b1;
						r.erase_count = 8'd1;
					end
				end
				KEY_NUL, KEY_ALT_C, KEY_ALT_O, KEY_ALT_L: ;
				default: begin
					// drop the key silently once the buffer is full
					if (used < DEPTH) begin
						ch = (rq.key_code == KEY_CR) ? KEY_LF : rq.key_code;
						line_mem[ed_pos[IDX_W-2:0]] = ch;
						ed_pos = ed_pos + 1'b1;
						used = ed_pos - rd_pos;
						r.echo_valid = 1'b1;
						r.echo_char = ch;
						if (ch == KEY_LF || ch == KEY_CTRL_D || used == DEPTH) begin
							cm_pos = ed_pos;
							r.line_ready = 1'b1;
						end
					end
				end
			endcase
		end else if (rd_pos == cm_pos) begin
			r.read_empty = 1'b1;
		end else begin
			ch = line_mem[rd_pos[IDX_W-2:0]];
			if (ch == KEY_CTRL_D) begin
				// end-of-file mark: consume it only at the start of a call
				if (rq.first_of_read)
					rd_pos = rd_pos + 1'b1;
				r.read_eof = 1'b1;
				r.read_stop = 1'b1;
			end else begin
				rd_pos = rd_pos + 1'b1;
				r.read_valid = 1'b1;
				r.read_char = ch;
				r.read_stop = (ch == KEY_LF);
			end
		end
		return r;
	endfunction

	function automatic cle_rsp_t typed_rsp(logic ev, logic [CHAR_W-1:0] ec,
			logic [7:0] er, logic lr, logic dr, logic re);
		cle_rsp_t r;
		r = '0;
		r.echo_valid = ev;
		r.echo_char = ec;
		r.erase_count = er;
		r.line_ready = lr;
		r.dump_request = dr;
		r.read_empty = re;
		return r;
	endfunction

	function automatic void add_row(logic kind, logic [CHAR_W-1:0] key, logic first,
			bit typed, cle_rsp_t want);
		plan_row_t row;
		row.kind = kind;
		row.key = key;
		row.first = first;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	function automatic string show_rsp(cle_rsp_t r);
		return $sformatf("echo %0b/%h erase %0d ready %0b dump %0b empty %0b read %0b/%h eof %0b stop %0b",
			r.echo_valid, r.echo_char, r.erase_count, r.line_ready, r.dump_request,
			r.read_empty, r.read_valid, r.read_char, r.read_eof, r.read_stop);
	endfunction

	function automatic logic [CHAR_W-1:0] printable_key();
		return CHAR_W'($urandom_range(8'h7E, 8'h20));
	endfunction

	// Offer one request, hold it until the editor takes it, then log the
	// result it owes. Drive at the falling edge, sample at the rising one.
	task automatic issue(input logic kind, input logic [CHAR_W-1:0] key,
			input logic first, input bit typed, input cle_rsp_t want);
		cle_req_t rq;
		rq.kind = kind;
		rq.key_code = key;
		rq.first_of_read = first;
		calm = (sent >= CALM_FROM && sent < CALM_FROM + CALM_LEN);
		@(negedge clk);
		while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= rq;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		last_rsp = apply_request(rq);
		owed_rsp.push_back(typed ? want : last_rsp);
		sent++;
		// track the reader: a call ends at a stop, and is open once a byte came
		if (kind == KIND_READ) begin
			if (last_rsp.read_stop)
				call_open = 1'b0;
			else if (last_rsp.read_valid)
				call_open = 1'b1;
		end
	endtask

	task automatic press(input logic [CHAR_W-1:0] key);
		issue(KIND_KEY, key, 1'($urandom_range(1, 0)), 1'b0, '0);
	endtask

	task automatic read_byte();
		issue(KIND_READ, CHAR_W'($urandom_range(255, 0)), !call_open, 1'b0, '0);
	endtask

	// Read until nothing committed is left.
	task automatic drain_lines();
		int guard;
		guard = 0;
		do begin
			read_byte();
			guard++;
		end while (!last_rsp.read_empty && guard < 4 * DEPTH);
	endtask

	// Result side: stall at random, except in the calm window.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp_ch.ready <= calm || $urandom_range(99, 0) >= IDLE_PCT;
		end
	end

	// Compare each taken result with the oldest one owed, field by field.
	always @(posedge clk) begin
		cle_rsp_t   want;
		logic [9:0] bad;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("cycle %0d: result with no request behind it: %s",
						cycles, show_rsp(rsp_ch.data));
			end else begin
				want = owed_rsp.pop_front();
				bad = {rsp_ch.data.echo_valid !== want.echo_valid,
					rsp_ch.data.echo_char !== want.echo_char,
					rsp_ch.data.erase_count !== want.erase_count,
					rsp_ch.data.line_ready !== want.line_ready,
					rsp_ch.data.dump_request !== want.dump_request,
					rsp_ch.data.read_empty !== want.read_empty,
					rsp_ch.data.read_valid !== want.read_valid,
					rsp_ch.data.read_char !== want.read_char,
					rsp_ch.data.read_eof !== want.read_eof,
					rsp_ch.data.read_stop !== want.read_stop};
				if (bad != '0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("cycle %0d: result mismatch, fields %b", cycles, bad);
						$display("  expected %s", show_rsp(want));
						$display("  actual   %s", show_rsp(rsp_ch.data));
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL console_line_editor");
			$finish;
		end
	end

	initial begin
		int                scene;
		int                pick;
		int                len;
		logic [CHAR_W-1:0] key;

		item_ch.valid = 1'b0;
		item_ch.data = '0;

		// Directed table: reset state, ignored codes, edits on an empty tail, the dump
		// key, erase and kill inside a line, CR mapping, and both end-of-file cases.
		add_row(KIND_READ, 8'h00, 1'b1, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 1));
		add_row(KIND_KEY, KEY_NUL, 1'b0, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_ALT_C, 1'b1, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_ALT_O, 1'b0, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_ALT_L, 1'b0, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_CTRL_U, 1'b0, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_CTRL_H, 1'b0, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_DEL, 1'b0, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_CTRL_P, 1'b0, 1'b1, typed_rsp(0, 8'h00, 0, 0, 1, 0));
		add_row(KIND_KEY, 8'h61, 1'b0, 1'b1, typed_rsp(1, 8'h61, 0, 0, 0, 0));
		add_row(KIND_KEY, 8'hFF, 1'b1, 1'b1, typed_rsp(1, 8'hFF, 0, 0, 0, 0));
		add_row(KIND_KEY, KEY_DEL, 1'b0, 1'b1, typed_rsp(0, 8'h00, 1, 0, 0, 0));
		add_row(KIND_KEY, 8'h01, 1'b0, 1'b0, '0);
		add_row(KIND_KEY, KEY_CTRL_U, 1'b0, 1'b1, typed_rsp(0, 8'h00, 2, 0, 0, 0));
		add_row(KIND_KEY, 8'h78, 1'b0, 1'b0, '0);
		add_row(KIND_KEY, KEY_CR, 1'b0, 1'b1, typed_rsp(1, KEY_LF, 0, 1, 0, 0));
		add_row(KIND_READ, 8'hFF, 1'b1, 1'b0, '0);
		add_row(KIND_READ, 8'h00, 1'b0, 1'b0, '0);
		add_row(KIND_READ, 8'h80, 1'b1, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 1));
		add_row(KIND_KEY, 8'h6B, 1'b0, 1'b0, '0);
		add_row(KIND_KEY, KEY_CTRL_D, 1'b0, 1'b1, typed_rsp(1, KEY_CTRL_D, 0, 1, 0, 0));
		add_row(KIND_READ, 8'h00, 1'b1, 1'b0, '0);
		add_row(KIND_READ, 8'h00, 1'b0, 1'b0, '0);  // mark stays for the next call
		add_row(KIND_READ, 8'h00, 1'b1, 1'b0, '0);  // now it is consumed
		add_row(KIND_READ, 8'h7F, 1'b1, 1'b1, typed_rsp(0, 8'h00, 0, 0, 0, 1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			issue(plan[i].kind, plan[i].key, plan[i].first, plan[i].typed, plan[i].want);

		// Random part: mostly typed lines then reads, with noise, bare reads
		// and now and then a run that fills the whole buffer.
		scene = 0;
		while (sent < plan.size() + RAND_ITEMS) begin
			if (scene % 40 == 20) begin
				// empty the buffer, then type to one short of full
				press(KEY_CTRL_U);
				drain_lines();
				repeat (DEPTH - 1)
					press(printable_key());
				if (scene % 80 == 60) begin
					press(KEY_CTRL_U);  // widest possible kill
				end else begin
					// the next key fills and commits, the rest are dropped
					repeat (12)
						press(printable_key());
				end
				press(KEY_DEL);
				drain_lines();
			end else begin
				pick = $urandom_range(99, 0);
				if (pick < 60) begin
					len = ($urandom_range(99, 0) < 5) ? $urandom_range(DEPTH + 4, 20)
						: $urandom_range(12, 0);
					repeat (len) begin
						pick = $urandom_range(99, 0);
						if (pick < 5)
							key = KEY_DEL;
						else if (pick < 8)
							key = KEY_CTRL_H;
						else if (pick < 11)
							key = KEY_CTRL_U;
						else if (pick < 15)
							key = CHAR_W'($urandom_range(255, 0));
						else
							key = printable_key();
						press(key);
					end
					pick = $urandom_range(2, 0);
					press(pick == 0 ? KEY_CR : (pick == 1 ? KEY_LF : KEY_CTRL_D));
					repeat ($urandom_range(len + 4, 0)) begin
						// let the reader give up on a call now and then
						if ($urandom_range(99, 0) < 5)
							call_open = 1'b0;
						read_byte();
					end
				end else if (pick < 80) begin
					repeat ($urandom_range(8, 1))
						issue(1'($urandom_range(1, 0)), CHAR_W'($urandom_range(255, 0)),
							1'($urandom_range(1, 0)), 1'b0, '0);
				end else begin
					repeat ($urandom_range(20, 1))
						read_byte();
				end
			end
			scene++;
		end

		@(negedge clk);
		item_ch.valid <= 1'b0;

		// Let every owed result arrive, then give the editor time to show
		// anything extra.
		while (owed_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0 && owed_rsp.size() == 0)
			$display("PASS console_line_editor");
		else
			$display("FAIL console_line_editor");
		$finish;
	end

endmodule

`default_nettype wire

### console_line_editor.f
hw/rtl/cle_pkg.sv
hw/rtl/cle_req_if.sv
hw/rtl/cle_rsp_if.sv
hw/rtl/cle_ram.sv
hw/rtl/cle_ctrl.sv
hw/rtl/cle_dp.sv
hw/rtl/console_line_editor.sv
sim/tb_top.sv
